// ----- src/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg
// Types and constants shared by the secondary interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sic_pkg;

  localparam int NUM_LINES = 32;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register word offsets
  localparam logic [9:0] REG_STATUS  = 10'd0;
  localparam logic [9:0] REG_RAWSTAT = 10'd1;
  localparam logic [9:0] REG_ENSET   = 10'd2;
  localparam logic [9:0] REG_ENCLR   = 10'd3;
  localparam logic [9:0] REG_SOFTSET = 10'd4;
  localparam logic [9:0] REG_SOFTCLR = 10'd5;
  localparam logic [9:0] REG_PTSET   = 10'd8;
  localparam logic [9:0] REG_PTCLR   = 10'd9;

  localparam logic [31:0] PT_ALLOWED    = 32'h7fe0_0000;
  localparam int          COMBINED_LINE = 31;

  typedef struct packed {
    cmd_t        command;
    logic [4:0]  line_number;
    logic        line_level;
    logic [9:0]  word_index;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] irq_lines;
    logic        bad_offset;
  } result_t;

endpackage

// ----- src/sic_in_stage.sv -----
// ----------------------------------------------------------------------------
// sic_in_stage
// Input register: captures one word from the slave side and unpacks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sic_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          advance,
  output logic          item_valid,
  output sic_pkg::item_t item
);
  import sic_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command     <= cmd_t'(in_tuser);
      item_r.line_number <= in_tdata[4:0];
      item_r.line_level  <= in_tdata[5];
      item_r.word_index  <= in_tdata[15:6];
      item_r.write_data  <= in_tdata[47:16];
    end
  end

endmodule

// ----- src/sic_exec.sv -----
// ----------------------------------------------------------------------------
// sic_exec
// Controller state and the single-pass update for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sic_exec (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            commit,
  input  sic_pkg::item_t  item,
  output sic_pkg::result_t result
);
  import sic_pkg::*;

  logic [31:0] raw_r, raw_nxt;
  logic [31:0] en_r, en_nxt;
  logic [31:0] pt_r, pt_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] rd;
  logic        bad;
  logic        refresh;
  logic        reeval;
  logic [31:0] line_bit;
  logic [31:0] pt_sel;
  logic [31:0] line_pt;

  assign line_bit = 32'd1 << item.line_number;

  always_comb begin
    raw_nxt = raw_r;
    en_nxt  = en_r;
    pt_nxt  = pt_r;
    rd      = '0;
    bad     = 1'b0;
    refresh = 1'b0;
    reeval  = 1'b0;
    case (item.command)
      CMD_LINE: begin
        raw_nxt = item.line_level ? (raw_r | line_bit) : (raw_r & ~line_bit);
        reeval  = 1'b1;
      end
      CMD_READ: begin
        case (item.word_index)
          REG_STATUS:  rd = raw_r & en_r;
          REG_RAWSTAT: rd = raw_r;
          REG_ENSET:   rd = en_r;
          REG_SOFTSET: rd = {31'd0, raw_r[0]};
          REG_PTSET:   rd = pt_r;
          default:     bad = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        reeval = 1'b1;
        case (item.word_index)
          REG_ENSET:   en_nxt = en_r | item.write_data;
          REG_ENCLR:   en_nxt = en_r & ~item.write_data;
          REG_SOFTSET: if (item.write_data != '0) en_nxt = en_r | 32'd1;
          REG_SOFTCLR: if (item.write_data != '0) en_nxt = en_r & ~32'd1;
          REG_PTSET: begin
            pt_nxt  = pt_r | (item.write_data & PT_ALLOWED);
            refresh = 1'b1;
          end
          REG_PTCLR: begin
            pt_nxt  = pt_r & ~item.write_data;
            refresh = 1'b1;
          end
          default: begin
            bad    = 1'b1;
            reeval = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Output line update: direct follow on a line change, refresh on pass-through
  // writes, then the combined line.
  always_comb begin
    pt_sel  = pt_nxt & PT_ALLOWED;
    line_pt = line_r;
    if (item.command == CMD_LINE && (pt_r & line_bit) != '0) begin
      line_pt = item.line_level ? (line_r | line_bit) : (line_r & ~line_bit);
    end
    if (refresh) begin
      line_pt = (line_r & ~pt_sel) | (raw_nxt & pt_sel);
    end
    line_nxt = line_pt;
    if (reeval) begin
      line_nxt[COMBINED_LINE] = |(raw_nxt & en_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= '0;
      en_r   <= '0;
      pt_r   <= '0;
      line_r <= '0;
    end else if (commit) begin
      raw_r  <= raw_nxt;
      en_r   <= en_nxt;
      pt_r   <= pt_nxt;
      line_r <= line_nxt;
    end
  end

  assign result.read_data  = rd;
  assign result.irq_lines  = line_nxt;
  assign result.bad_offset = bad;

endmodule

// ----- src/sic_out_stage.sv -----
// ----------------------------------------------------------------------------
// sic_out_stage
// Result register: holds one result word until the master side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sic_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  input  sic_pkg::result_t result,
  output logic             advance,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,
  output logic [0:0]       out_tuser
);
  import sic_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.irq_lines, res_r.read_data};
  assign out_tuser  = res_r.bad_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res_r <= result;
    end
  end

endmodule

// ----- src/secondary_interrupt_controller_core.sv -----
// The input word is held in the input register, and its result is captured in the
// result register, which loads only while the result side is free.
// Throughput: one word per cycle; input register, one pass of update logic,
// result register. The input side stalls only while the result is held.
// Reset (rst_n low, synchronous): line levels, enables, pass-through bits and
// output lines clear to zero; both stage registers empty.
// ----------------------------------------------------------------------------
// secondary_interrupt_controller_core
// 32-line secondary interrupt controller with stream-style ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module secondary_interrupt_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // line_number, line_level, word_index, write_data
  input  logic [1:0]  in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // read_data, irq_lines
  output logic [0:0]  out_tuser  // bad_offset
);
  import sic_pkg::*;

  logic    item_valid;
  logic    advance;
  item_t   item;
  result_t result;

  sic_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sic_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (item_valid && advance),
    .item   (item),
    .result (result)
  );

  sic_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // input side backs up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // a bad offset never returns data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[31:0] == 32'd0))
    else $error("bad offset with nonzero read data");

  // lines 0..20 are never driven
  a_low_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[52:32] == 21'd0))
    else $error("undriven output line set");
`endif

endmodule

// ----- tb/secondary_interrupt_controller_core_tb.sv -----
// ----------------------------------------------------------------------------
// secondary_interrupt_controller_core_tb
// Self-checking bench for the secondary interrupt controller. Line changes,
// register reads and writes go in as stream words. Every accepted word is
// run through a local prediction of the controller state, and each result
// word is compared with the oldest prediction. Both sides idle at random,
// and one phase holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module secondary_interrupt_controller_core_tb;
  import sic_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1650;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // line_number, line_level, word_index, write_data
  logic [1:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // read_data, irq_lines
  logic [0:0]  out_tuser;  // bad_offset

  // predicted controller state
  logic [31:0] raw_lvl;
  logic [31:0] en_mask;
  logic [31:0] pt_en;
  logic [31:0] line_lvl;

  result_t irq_result_q[$];
  int      mismatch_cnt;
  int      cycle_cnt;
  bit      idle_en;
  bit      hold_off_req;

  secondary_interrupt_controller_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advance the predicted state by one word and return the result it gives.
  function automatic result_t sic_compute(item_t it);
    result_t     r;
    logic [31:0] bit_m;
    r     = '0;
    bit_m = 32'h1 << it.line_number;
    case (it.command)
      CMD_LINE: begin
        if (it.line_level) raw_lvl = raw_lvl | bit_m;
        else raw_lvl = raw_lvl & ~bit_m;
        if ((pt_en & bit_m) != 0) begin
          if (it.line_level) line_lvl = line_lvl | bit_m;
          else line_lvl = line_lvl & ~bit_m;
        end
        line_lvl[COMBINED_LINE] = |(raw_lvl & en_mask);
      end
      CMD_READ: begin
        case (it.word_index)
          REG_STATUS:  r.read_data = raw_lvl & en_mask;
          REG_RAWSTAT: r.read_data = raw_lvl;
          REG_ENSET:   r.read_data = en_mask;
          REG_SOFTSET: r.read_data = {31'd0, raw_lvl[0]};
          REG_PTSET:   r.read_data = pt_en;
          default:     r.bad_offset = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        case (it.word_index)
          REG_ENSET: en_mask = en_mask | it.write_data;
          REG_ENCLR: en_mask = en_mask & ~it.write_data;
          REG_SOFTSET: begin
            if (it.write_data != 0) en_mask[0] = 1'b1;
          end
          REG_SOFTCLR: begin
            if (it.write_data != 0) en_mask[0] = 1'b0;
          end
          REG_PTSET: begin
            pt_en    = pt_en | (it.write_data & PT_ALLOWED);
            // pass-through bits only exist on lines 21..30
            line_lvl = (line_lvl & ~pt_en) | (raw_lvl & pt_en);
          end
          REG_PTCLR: begin
            pt_en    = pt_en & ~it.write_data;
            line_lvl = (line_lvl & ~pt_en) | (raw_lvl & pt_en);
          end
          default: r.bad_offset = 1'b1;
        endcase
        if (!r.bad_offset) line_lvl[COMBINED_LINE] = |(raw_lvl & en_mask);
      end
      default: ;
    endcase
    r.irq_lines = line_lvl;
    return r;
  endfunction

  // Offer one word; valid stays high afterwards so back-to-back words need no
  // drop. The caller lowers it once the stream is done.
  task automatic send_word(input cmd_t cmd, input logic [4:0] ln, input logic lv,
                           input logic [9:0] wi, input logic [31:0] wd);
    item_t it;
    int    gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.command     = cmd;
    it.line_number = ln;
    it.line_level  = lv;
    it.word_index  = wi;
    it.write_data  = wd;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {wd, wi, lv, ln};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    irq_result_q.push_back(sic_compute(it));
  endtask

  task automatic line_word(input logic [4:0] ln, input logic lv);
    send_word(CMD_LINE, ln, lv, 10'($urandom), $urandom);
  endtask

  task automatic read_word(input logic [9:0] wi);
    send_word(CMD_READ, 5'($urandom), 1'($urandom), wi, $urandom);
  endtask

  task automatic write_word(input logic [9:0] wi, input logic [31:0] wd);
    send_word(CMD_WRITE, 5'($urandom), 1'($urandom), wi, wd);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data  = out_tdata[31:0];
      got.irq_lines  = out_tdata[63:32];
      got.bad_offset = out_tuser[0];
      if (irq_result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: rd=%h irq=%h bad=%b",
                   got.read_data, got.irq_lines, got.bad_offset);
      end else begin
        want = irq_result_q.pop_front();
        if (got.read_data !== want.read_data || got.irq_lines !== want.irq_lines ||
            got.bad_offset !== want.bad_offset) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp rd=%h irq=%h bad=%b  got rd=%h irq=%h bad=%b",
                     want.read_data, want.irq_lines, want.bad_offset,
                     got.read_data, got.irq_lines, got.bad_offset);
        end
      end
    end
  end

  task automatic test_reset_state();
    read_word(REG_STATUS);
    read_word(REG_RAWSTAT);
    read_word(REG_ENSET);
    read_word(REG_SOFTSET);
    read_word(REG_PTSET);
    read_word(REG_ENCLR);      // write-only, reads as bad offset
    read_word(10'h3ff);
  endtask

  task automatic test_enable_and_lines();
    line_word(5'd0, 1'b1);
    line_word(5'd31, 1'b1);
    write_word(REG_ENSET, 32'hffff_ffff);
    read_word(REG_STATUS);
    write_word(REG_ENCLR, 32'h8000_0000);
    write_word(REG_SOFTCLR, 32'h0000_0000);  // zero data leaves enable bit 0
    write_word(REG_SOFTCLR, 32'h0000_0100);
    line_word(5'd0, 1'b0);
    write_word(REG_SOFTSET, 32'h0000_0000);
    write_word(REG_SOFTSET, 32'h8000_0000);
  endtask

  task automatic test_passthrough();
    line_word(5'd25, 1'b1);
    write_word(REG_PTSET, 32'hffff_ffff);    // only lines 21..30 take it
    line_word(5'd25, 1'b0);
    line_word(5'd21, 1'b1);
    line_word(5'd30, 1'b1);
    write_word(REG_PTCLR, 32'hffff_ffff);
    line_word(5'd30, 1'b0);                  // output line holds high
    write_word(10'd6, 32'hffff_ffff);
    write_word(10'h3ff, 32'hffff_ffff);
    send_word(CMD_NONE, 5'd31, 1'b1, REG_ENSET, 32'hffff_ffff);
  endtask

  task automatic random_word();
    int          r;
    logic [9:0]  wi;
    logic [31:0] wd;
    logic [4:0]  ln;
    r  = $urandom_range(0, 99);
    wi = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 9)) : 10'($urandom);
    case ($urandom_range(0, 9))
      0:       wd = 32'h0;
      1:       wd = 32'hffff_ffff;
      2:       wd = 32'h1 << $urandom_range(0, 31);
      default: wd = $urandom;
    endcase
    ln = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(21, 31)) : 5'($urandom);
    if (r < 40) send_word(CMD_LINE, ln, 1'($urandom), 10'($urandom), $urandom);
    else if (r < 65) send_word(CMD_READ, ln, 1'($urandom), wi, $urandom);
    else if (r < 96) send_word(CMD_WRITE, ln, 1'($urandom), wi, wd);
    else send_word(CMD_NONE, ln, 1'($urandom), wi, wd);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) random_word();
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random(40);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random(200);
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_LINE;
    raw_lvl      = '0;
    en_mask      = '0;
    pt_en        = '0;
    line_lvl     = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    idle_en      = 1'b1;
    hold_off_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_enable_and_lines();
    test_passthrough();
    test_random(RANDOM_WORDS / 2);
    test_backpressure();
    test_back_to_back();
    test_random(RANDOM_WORDS - RANDOM_WORDS / 2 - 240);
    in_tvalid <= 1'b0;

    while (irq_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && irq_result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
